// ===== hw/rtl/cfwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame link package
// Shared types and constants for the command link endpoint and its status reply.
// ----------------------------------------------------------------------------
package cfwl_pkg;

    // Frame delimiters and register reset value.
    localparam logic [7:0]  FRAME_START   = 8'h24;
    localparam logic [7:0]  FRAME_END     = 8'h23;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    // Reply geometry: start byte, status snapshot, end byte.
    localparam int SNAP_LEN  = 13;
    localparam int REPLY_LEN = SNAP_LEN + 2;
    localparam int BEAT_W    = $clog2(REPLY_LEN);

    // Item kinds.
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_SNAP = 2'd2;

    // Output request bits of the frame.
    localparam logic [7:0] REQ_ROLLER = 8'h01;
    localparam logic [7:0] REQ_VALVE  = 8'h02;

    // Mode byte value that selects manual operation.
    localparam logic [7:0] MODE_MANUAL = 8'h01;

    typedef enum logic [2:0] {
        PH_START,
        PH_MODE,
        PH_CMD,
        PH_OUT,
        PH_TRAIL
    } t_phase;

    typedef logic [SNAP_LEN-1:0][7:0]  t_snap;
    typedef logic [REPLY_LEN-1:0][7:0] t_reply;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  rx_byte;
        logic [7:0]  app_status;
        logic [3:0]  switch_bits;
        logic [1:0]  output_bits;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] len_a;
        logic [15:0] len_b;
        logic [7:0]  pwm_left;
        logic [7:0]  pwm_right;
    } t_item;

    typedef struct packed {
        logic       manual_mode;
        logic [7:0] drive_command;
        logic       roller_request;
        logic       valve_request;
        logic       link_up;
    } t_status;

    typedef struct packed {
        logic    frame_done;
        t_status status;
        t_snap   snap;
    } t_result;

endpackage

// ===== hw/rtl/cfwl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame link channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------

// Input item channel.
interface cfwl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [7:0]  app_status;
    logic [3:0]  switch_bits;
    logic [1:0]  output_bits;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] len_a;
    logic [15:0] len_b;
    logic [7:0]  pwm_left;
    logic [7:0]  pwm_right;

    modport source (
        output valid, command, rx_byte, app_status, switch_bits, output_bits,
               pos_x, pos_y, len_a, len_b, pwm_left, pwm_right,
        input  ready
    );
    modport sink (
        input  valid, command, rx_byte, app_status, switch_bits, output_bits,
               pos_x, pos_y, len_a, len_b, pwm_left, pwm_right,
        output ready
    );
endinterface

// Result item channel.
interface cfwl_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       manual_mode;
    logic [7:0] drive_command;
    logic       roller_request;
    logic       valve_request;
    logic       link_up;

    modport source (
        output valid, tx_valid, tx_byte, last, manual_mode, drive_command,
               roller_request, valve_request, link_up,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_byte, last, manual_mode, drive_command,
               roller_request, valve_request, link_up,
        output ready
    );
endinterface

// Configuration write channel for the timeout register.
interface cfwl_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/command_frame_link_with_watchdog_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame link with watchdog, top level
// The first result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle when each item yields one result and the
// result side is ready. A completed frame yields a 15-byte reply; the next
// item is taken as its last byte leaves.
// Reset (synchronous, active low) clears the link state, the snapshot, the
// result valid flag and beat count and loads the timeout with 5000 ms.
// ----------------------------------------------------------------------------
module command_frame_link_with_watchdog_top
    import cfwl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cfwl_in_if.sink  i_in,
    cfwl_cfg_if.sink i_cfg,
    cfwl_out_if.source o_out
);

    t_item   w_item;
    t_result w_result;
    logic    w_ready;
    logic    w_accept;
    logic    w_cfg_we;

    // Input handshake.
    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    // Configuration is always taken.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    // Gather the input item fields.
    always_comb begin
        w_item.command     = i_in.command;
        w_item.rx_byte     = i_in.rx_byte;
        w_item.app_status  = i_in.app_status;
        w_item.switch_bits = i_in.switch_bits;
        w_item.output_bits = i_in.output_bits;
        w_item.pos_x       = i_in.pos_x;
        w_item.pos_y       = i_in.pos_y;
        w_item.len_a       = i_in.len_a;
        w_item.len_b       = i_in.len_b;
        w_item.pwm_left    = i_in.pwm_left;
        w_item.pwm_right   = i_in.pwm_right;
    end

    cfwl_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (w_item),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (i_cfg.data),
        .o_result   (w_result)
    );

    cfwl_reply u_reply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_result (w_result),
        .o_ready  (w_ready),
        .o_out    (o_out)
    );

endmodule

// ===== hw/rtl/cfwl_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame link decoder
// Frame parser, request registers, idle watchdog and status snapshot store.
// ----------------------------------------------------------------------------
module cfwl_decode
    import cfwl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_item       i_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output t_result     o_result
);

    t_phase      r_phase, n_phase;
    logic        r_manual, n_manual;
    logic [7:0]  r_cmd, n_cmd;
    logic        r_roller, n_roller;
    logic        r_valve, n_valve;
    logic        r_link, n_link;
    logic [15:0] r_idle, n_idle;
    logic        r_running, n_running;
    logic [15:0] r_timeout;
    t_snap       r_snap, n_snap;
    logic        w_is_rx;
    logic        w_done;

    assign w_is_rx = i_accept && (i_item.command == KIND_RX);
    assign w_done  = w_is_rx && (r_phase == PH_TRAIL);

    // Frame phase: next state.
    always_comb begin
        n_phase = r_phase;
        if (w_is_rx) begin
            case (r_phase)
                PH_START: begin
                    if (i_item.rx_byte == FRAME_START) begin
                        n_phase = PH_MODE;
                    end
                end
                PH_MODE:  n_phase = PH_CMD;
                PH_CMD:   n_phase = PH_OUT;
                PH_OUT:   n_phase = PH_TRAIL;
                PH_TRAIL: n_phase = PH_START;
                default:  n_phase = PH_START;
            endcase
        end
    end

    // Request, watchdog and snapshot updates for the accepted item.
    always_comb begin
        n_manual  = r_manual;
        n_cmd     = r_cmd;
        n_roller  = r_roller;
        n_valve   = r_valve;
        n_link    = r_link;
        n_idle    = r_idle;
        n_running = r_running;
        n_snap    = r_snap;
        if (i_accept) begin
            case (i_item.command)
                KIND_RX: begin
                    case (r_phase)
                        PH_MODE:  n_manual = (i_item.rx_byte == MODE_MANUAL);
                        PH_CMD:   n_cmd = i_item.rx_byte;
                        PH_OUT: begin
                            n_roller = |(i_item.rx_byte & REQ_ROLLER);
                            n_valve  = |(i_item.rx_byte & REQ_VALVE);
                        end
                        PH_TRAIL: begin
                            n_link    = 1'b1;
                            n_idle    = '0;
                            n_running = 1'b1;
                        end
                        default: ;
                    endcase
                end
                KIND_TICK: begin
                    if (r_running) begin
                        if (r_idle >= r_timeout) begin
                            n_manual  = 1'b0;
                            n_cmd     = '0;
                            n_roller  = 1'b0;
                            n_valve   = 1'b0;
                            n_link    = 1'b0;
                            n_running = 1'b0;
                            n_idle    = '0;
                        end else begin
                            n_idle = r_idle + 16'd1;
                        end
                    end
                end
                KIND_SNAP: begin
                    n_snap[0]  = i_item.app_status;
                    n_snap[1]  = {4'b0000, i_item.switch_bits};
                    n_snap[2]  = {6'b000000, i_item.output_bits};
                    n_snap[3]  = i_item.pos_x[15:8];
                    n_snap[4]  = i_item.pos_x[7:0];
                    n_snap[5]  = i_item.pos_y[15:8];
                    n_snap[6]  = i_item.pos_y[7:0];
                    n_snap[7]  = i_item.len_a[15:8];
                    n_snap[8]  = i_item.len_a[7:0];
                    n_snap[9]  = i_item.len_b[15:8];
                    n_snap[10] = i_item.len_b[7:0];
                    n_snap[11] = i_item.pwm_left;
                    n_snap[12] = i_item.pwm_right;
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_manual  <= 1'b0;
            r_cmd     <= '0;
            r_roller  <= 1'b0;
            r_valve   <= 1'b0;
            r_link    <= 1'b0;
            r_idle    <= '0;
            r_running <= 1'b0;
            r_snap    <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_phase   <= n_phase;
            r_manual  <= n_manual;
            r_cmd     <= n_cmd;
            r_roller  <= n_roller;
            r_valve   <= n_valve;
            r_link    <= n_link;
            r_idle    <= n_idle;
            r_running <= n_running;
            r_snap    <= n_snap;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // The reply reports the state after the item and the snapshot before it.
    always_comb begin
        o_result.frame_done            = w_done;
        o_result.status.manual_mode    = n_manual;
        o_result.status.drive_command  = n_cmd;
        o_result.status.roller_request = n_roller;
        o_result.status.valve_request  = n_valve;
        o_result.status.link_up        = n_link;
        o_result.snap                  = r_snap;
    end

    // The link flag and the idle timer are set and cleared together.
    a_link_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link == r_running)
        else $error("link flag and idle timer disagree");

    // A stopped timer always holds zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_idle == 16'd0))
        else $error("idle count nonzero while timer stopped");

    // A completed frame brings the link up and restarts the count.
    a_frame_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_link && r_idle == 16'd0 && r_phase == PH_START))
        else $error("completed frame did not restart the link");

endmodule

// ===== hw/rtl/cfwl_reply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame link reply serializer
// Result register that sends one status item or a fifteen-byte reply frame.
// ----------------------------------------------------------------------------
module cfwl_reply
    import cfwl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_result    i_result,
    output logic       o_ready,
    cfwl_out_if.source o_out
);

    logic              r_valid;
    logic              r_tx_valid;
    logic [BEAT_W-1:0] r_remain;
    t_reply            r_sr;
    t_status           r_status;
    logic              w_take;
    logic              w_last;

    assign w_last  = (r_remain == '0);
    assign w_take  = r_valid && o_out.ready;
    // A new item may load once the final result of the previous one leaves.
    assign o_ready = !r_valid || (o_out.ready && w_last);

    // Control registers: valid flag and remaining beat count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_remain <= '0;
        end else if (i_accept) begin
            r_valid  <= 1'b1;
            r_remain <= i_result.frame_done ? BEAT_W'(REPLY_LEN - 1) : '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_remain <= r_remain - BEAT_W'(1);
            end
        end
    end

    // Payload: reply shift line and status captured with the item.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tx_valid <= i_result.frame_done;
            r_status   <= i_result.status;
            if (i_result.frame_done) begin
                r_sr <= {FRAME_END, i_result.snap, FRAME_START};
            end else begin
                r_sr <= '0;
            end
        end else if (w_take && !w_last) begin
            r_sr <= {8'h00, r_sr[REPLY_LEN-1:1]};
        end
    end

    // Result channel.
    always_comb begin
        o_out.valid          = r_valid;
        o_out.tx_valid       = r_tx_valid;
        o_out.tx_byte        = r_sr[0];
        o_out.last           = w_last;
        o_out.manual_mode    = r_status.manual_mode;
        o_out.drive_command  = r_status.drive_command;
        o_out.roller_request = r_status.roller_request;
        o_out.valve_request  = r_status.valve_request;
        o_out.link_up        = r_status.link_up;
    end

    // Only a reply frame spans more than one result.
    a_multi_is_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !w_last) |-> r_tx_valid)
        else $error("multi-beat result without reply bytes");

    // A taken non-final beat steps the count down by one.
    a_beat_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_last) |=> (r_valid && r_remain == $past(r_remain) - BEAT_W'(1)))
        else $error("reply beat count did not advance");

    // No new item loads while a reply is still in flight.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !w_last) |-> !o_ready)
        else $error("input accepted during reply");

endmodule

// ===== dv/link_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame link reply checker
// Watches the item, result and timeout channels of the command link endpoint.
// Keeps its own copy of the frame parser, the watchdog and the status
// snapshot, works out the results each accepted item must cause and compares
// every accepted result, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module link_reply_checker
    import cfwl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cfwl_in_if   i_in,
    cfwl_cfg_if  i_cfg,
    cfwl_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    // One expected result item.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       manual_mode;
        logic [7:0] drive_command;
        logic       roller_request;
        logic       valve_request;
        logic       link_up;
    } t_beat;

    t_beat       reply_beats[$];
    logic [15:0] timeout_ms;
    t_phase      phase;
    logic        manual_flag;
    logic [7:0]  command_code;
    logic        roller_req;
    logic        valve_req;
    logic        link_flag;
    logic [15:0] idle_count;
    logic        timer_running;
    logic [7:0]  snap_bytes [SNAP_LEN];
    int          mismatch_count = 0;
    int          beat_index = 0;

    assign o_fail_count = mismatch_count;

    // Queues one result that reports the link state as it stands now.
    function automatic void push_beat(input logic tx_valid, input logic [7:0] tx_byte,
                                      input logic last);
        t_beat b;
        b.tx_valid       = tx_valid;
        b.tx_byte        = tx_byte;
        b.last           = last;
        b.manual_mode    = manual_flag;
        b.drive_command  = command_code;
        b.roller_request = roller_req;
        b.valve_request  = valve_req;
        b.link_up        = link_flag;
        reply_beats.push_back(b);
    endfunction

    // Applies one item to the link state and queues the results it causes.
    function automatic void apply_link_item(input t_item it);
        int i;
        case (it.command)
            KIND_RX: begin
                case (phase)
                    PH_START: begin
                        if (it.rx_byte == FRAME_START) phase = PH_MODE;
                    end
                    PH_MODE: begin
                        manual_flag = (it.rx_byte == MODE_MANUAL);
                        phase = PH_CMD;
                    end
                    PH_CMD: begin
                        command_code = it.rx_byte;
                        phase = PH_OUT;
                    end
                    PH_OUT: begin
                        roller_req = |(it.rx_byte & REQ_ROLLER);
                        valve_req  = |(it.rx_byte & REQ_VALVE);
                        phase = PH_TRAIL;
                    end
                    default: begin
                        // The trailer byte closes the frame whatever its value.
                        phase = PH_START;
                        link_flag = 1'b1;
                        idle_count = '0;
                        timer_running = 1'b1;
                        push_beat(1'b1, FRAME_START, 1'b0);
                        for (i = 0; i < SNAP_LEN; i++) push_beat(1'b1, snap_bytes[i], 1'b0);
                        push_beat(1'b1, FRAME_END, 1'b1);
                        return;
                    end
                endcase
            end
            KIND_TICK: begin
                // The watchdog only runs once a frame has been seen.
                if (timer_running) begin
                    if (idle_count >= timeout_ms) begin
                        manual_flag = 1'b0;
                        command_code = '0;
                        roller_req = 1'b0;
                        valve_req = 1'b0;
                        link_flag = 1'b0;
                        timer_running = 1'b0;
                        idle_count = '0;
                    end else begin
                        idle_count = idle_count + 16'd1;
                    end
                end
            end
            KIND_SNAP: begin
                snap_bytes[0]  = it.app_status;
                snap_bytes[1]  = {4'h0, it.switch_bits};
                snap_bytes[2]  = {6'h0, it.output_bits};
                snap_bytes[3]  = it.pos_x[15:8];
                snap_bytes[4]  = it.pos_x[7:0];
                snap_bytes[5]  = it.pos_y[15:8];
                snap_bytes[6]  = it.pos_y[7:0];
                snap_bytes[7]  = it.len_a[15:8];
                snap_bytes[8]  = it.len_a[7:0];
                snap_bytes[9]  = it.len_b[15:8];
                snap_bytes[10] = it.len_b[7:0];
                snap_bytes[11] = it.pwm_left;
                snap_bytes[12] = it.pwm_right;
            end
            default: begin
            end
        endcase
        push_beat(1'b0, 8'h00, 1'b1);
    endfunction

    // Prints one line per mismatch and counts them all.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("%0t ns: result %0d, %s is %0h, expected %0h",
                 $time, beat_index, what, got, want);
    endtask

    // Channels are sampled at the rising edge, on the values from before it.
    always @(posedge i_clk) begin : watch
        t_item seen;
        t_beat want;
        int    i;
        if (!i_rst_n) begin
            timeout_ms = TIMEOUT_RESET;
            phase = PH_START;
            manual_flag = 1'b0;
            command_code = '0;
            roller_req = 1'b0;
            valve_req = 1'b0;
            link_flag = 1'b0;
            idle_count = '0;
            timer_running = 1'b0;
            for (i = 0; i < SNAP_LEN; i++) snap_bytes[i] = '0;
            reply_beats.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                timeout_ms = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                seen.command     = i_in.command;
                seen.rx_byte     = i_in.rx_byte;
                seen.app_status  = i_in.app_status;
                seen.switch_bits = i_in.switch_bits;
                seen.output_bits = i_in.output_bits;
                seen.pos_x       = i_in.pos_x;
                seen.pos_y       = i_in.pos_y;
                seen.len_a       = i_in.len_a;
                seen.len_b       = i_in.len_b;
                seen.pwm_left    = i_in.pwm_left;
                seen.pwm_right   = i_in.pwm_right;
                apply_link_item(seen);
            end
            if (i_out.valid && i_out.ready) begin
                if (reply_beats.size() == 0) begin
                    report_mismatch("unexpected result, tx_byte", i_out.tx_byte, 8'h00);
                end else begin
                    want = reply_beats.pop_front();
                    if (i_out.tx_valid !== want.tx_valid)
                        report_mismatch("tx_valid", 8'(i_out.tx_valid), 8'(want.tx_valid));
                    if (i_out.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", i_out.tx_byte, want.tx_byte);
                    if (i_out.last !== want.last)
                        report_mismatch("last", 8'(i_out.last), 8'(want.last));
                    if (i_out.manual_mode !== want.manual_mode)
                        report_mismatch("manual_mode", 8'(i_out.manual_mode),
                                        8'(want.manual_mode));
                    if (i_out.drive_command !== want.drive_command)
                        report_mismatch("drive_command", i_out.drive_command,
                                        want.drive_command);
                    if (i_out.roller_request !== want.roller_request)
                        report_mismatch("roller_request", 8'(i_out.roller_request),
                                        8'(want.roller_request));
                    if (i_out.valve_request !== want.valve_request)
                        report_mismatch("valve_request", 8'(i_out.valve_request),
                                        8'(want.valve_request));
                    if (i_out.link_up !== want.link_up)
                        report_mismatch("link_up", 8'(i_out.link_up), 8'(want.link_up));
                end
                beat_index++;
            end
        end
        o_pending <= reply_beats.size();
    end

endmodule

// ===== dv/command_frame_link_with_watchdog_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame link with watchdog, testbench
// Drives received bytes, millisecond ticks and status snapshots into the
// endpoint: a directed opening, then random phases at several timeout
// settings, mostly well-formed frames mixed with tick bursts and noise. Both
// sides idle at random, and the receiver once holds off long enough to stall
// the input. The checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module command_frame_link_with_watchdog_top_tb;
    import cfwl_pkg::*;

    // Item kind that the block answers without acting on it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    bit   steady;
    logic [15:0] cur_timeout;

    cfwl_in_if  in_ch ();
    cfwl_cfg_if cfg_ch ();
    cfwl_out_if out_ch ();

    command_frame_link_with_watchdog_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    link_reply_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offers one item, after an occasional idle gap, and waits until it is taken.
    task automatic drive_item(input t_item it);
        if (!steady && $urandom_range(0, 99) < 30) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= it.command;
        in_ch.rx_byte     <= it.rx_byte;
        in_ch.app_status  <= it.app_status;
        in_ch.switch_bits <= it.switch_bits;
        in_ch.output_bits <= it.output_bits;
        in_ch.pos_x       <= it.pos_x;
        in_ch.pos_y       <= it.pos_y;
        in_ch.len_a       <= it.len_a;
        in_ch.len_b       <= it.len_b;
        in_ch.pwm_left    <= it.pwm_left;
        in_ch.pwm_right   <= it.pwm_right;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Sends an item of the given kind; the fields it does not use are random.
    task automatic send(input logic [1:0] kind, input logic [7:0] rx);
        t_item it;
        it.command     = kind;
        it.rx_byte     = rx;
        it.app_status  = 8'($urandom);
        it.switch_bits = 4'($urandom);
        it.output_bits = 2'($urandom);
        it.pos_x       = 16'($urandom);
        it.pos_y       = 16'($urandom);
        it.len_a       = 16'($urandom);
        it.len_b       = 16'($urandom);
        it.pwm_left    = 8'($urandom);
        it.pwm_right   = 8'($urandom);
        drive_item(it);
    endtask

    // Sends a snapshot item with every field at its lowest or highest value.
    task automatic send_flat_snapshot(input bit all_ones);
        t_item it;
        it = all_ones ? '1 : '0;
        it.command = KIND_SNAP;
        drive_item(it);
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes the timeout register while the block is idle.
    task automatic write_timeout(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_timeout = value;
    endtask

    // Random traffic: mostly whole frames and tick bursts long enough to
    // trip the watchdog at short timeouts, the rest partial frames and noise.
    task automatic run_random_phase(input int n_items);
        int count;
        int pick;
        int burst;
        int k;
        count = 0;
        while (count < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send(KIND_RX, FRAME_START);
                send(KIND_RX, ($urandom_range(0, 1) != 0) ? MODE_MANUAL : 8'($urandom));
                send(KIND_RX, 8'($urandom));
                send(KIND_RX, 8'($urandom));
                send(KIND_RX, ($urandom_range(0, 1) != 0) ? FRAME_END : 8'($urandom));
                count += 5;
            end else if (pick < 68) begin
                burst = (cur_timeout <= 16'd40) ? $urandom_range(1, cur_timeout + 3)
                                                : $urandom_range(1, 6);
                for (k = 0; k < burst; k++) send(KIND_TICK, 8'($urandom));
                count += burst;
            end else if (pick < 78) begin
                send(KIND_SNAP, 8'($urandom));
                count++;
            end else if (pick < 86) begin
                // A partial frame interrupted by a tick or a snapshot update.
                burst = $urandom_range(1, 3);
                send(KIND_RX, FRAME_START);
                for (k = 0; k < burst; k++) send(KIND_RX, 8'($urandom));
                send(($urandom_range(0, 1) != 0) ? KIND_TICK : KIND_SNAP, 8'($urandom));
                count += burst + 2;
            end else if (pick < 95) begin
                send(KIND_RX, 8'($urandom));
                count++;
            end else begin
                send(KIND_UNUSED, 8'($urandom));
                count++;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off once 150 items have been sent.
    initial begin : receiver
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= 150) begin
                held = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.command     <= KIND_RX;
        in_ch.rx_byte     <= '0;
        in_ch.app_status  <= '0;
        in_ch.switch_bits <= '0;
        in_ch.output_bits <= '0;
        in_ch.pos_x       <= '0;
        in_ch.pos_y       <= '0;
        in_ch.len_a       <= '0;
        in_ch.len_b       <= '0;
        in_ch.pwm_left    <= '0;
        in_ch.pwm_right   <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        items_sent = 0;
        steady = 1'b0;
        cur_timeout = TIMEOUT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: tick before any frame, snapshot extremes, stray
        // byte, manual frame with all requests, plain frame with a wrong
        // trailer, unknown item kind, odd mode byte, ticks while running.
        send(KIND_TICK, 8'h00);
        send_flat_snapshot(1'b1);
        send(KIND_RX, 8'h00);
        send(KIND_RX, FRAME_START);
        send(KIND_RX, MODE_MANUAL);
        send(KIND_RX, 8'hFF);
        send(KIND_RX, REQ_ROLLER | REQ_VALVE);
        send(KIND_RX, FRAME_END);
        send_flat_snapshot(1'b0);
        send(KIND_UNUSED, 8'hFF);
        send(KIND_RX, FRAME_START);
        send(KIND_RX, 8'h00);
        send(KIND_RX, 8'h00);
        send(KIND_RX, 8'h00);
        send(KIND_RX, 8'h00);
        send(KIND_RX, FRAME_START);
        send(KIND_RX, 8'hFF);
        send(KIND_RX, 8'h5A);
        send(KIND_RX, REQ_VALVE);
        send(KIND_RX, 8'hFF);
        send(KIND_TICK, 8'hFF);
        send(KIND_TICK, 8'h00);

        // Random phases at the reset timeout and at several written ones.
        run_random_phase(60);
        settle();
        write_timeout(16'hFFFF);
        run_random_phase(60);
        settle();
        write_timeout(16'd1);
        run_random_phase(60);
        settle();
        write_timeout(16'd3);
        steady = 1'b1;
        run_random_phase(60);
        settle();
        steady = 1'b0;
        write_timeout(16'($urandom_range(2, 30)));
        run_random_phase(60);
        settle();
        write_timeout(TIMEOUT_RESET);
        run_random_phase(60);
        settle();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
